// ===== design/pcle_pkg.sv =====
// shared types, codes and helper functions of the pad controller led event engine
package pcle_pkg;

    // item function codes
    localparam logic [1:0] FUNC_EVENT = 2'd0;
    localparam logic [1:0] FUNC_SYNC  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACTION = 2'd0;
    localparam logic [1:0] KIND_LAMP   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // deck actions
    localparam logic [1:0] ACT_CUE       = 2'd0;
    localparam logic [1:0] ACT_UNCUE     = 2'd1;
    localparam logic [1:0] ACT_PUNCH_IN  = 2'd2;
    localparam logic [1:0] ACT_PUNCH_OUT = 2'd3;

    // pad modes
    localparam logic [1:0] MODE_CUE  = 2'd0;
    localparam logic [1:0] MODE_LOOP = 2'd1;
    localparam logic [1:0] MODE_ROLL = 2'd2;

    // configuration register indexes
    localparam logic REG_LEFT_PRESENT  = 1'b0;
    localparam logic REG_RIGHT_PRESENT = 1'b1;

    // event byte codes
    localparam logic [7:0] ST_LEFT_BASE  = 8'h9a;
    localparam logic [7:0] ST_LEFT_TOP   = 8'h9c;
    localparam logic [7:0] ST_RIGHT_BASE = 8'h9d;
    localparam logic [7:0] ST_RIGHT_TOP  = 8'h9f;
    localparam logic [7:0] NOTE_PLAIN    = 8'h3c;
    localparam logic [7:0] NOTE_SHIFT    = 8'h41;
    localparam logic [7:0] VEL_RELEASE   = 8'h00;
    localparam logic [7:0] VEL_PRESS     = 8'h7f;
    localparam logic [7:0] PLUG_STATUS   = 8'hba;
    localparam logic [7:0] PLUG_NOTE     = 8'h11;
    localparam logic [7:0] PLUG_VEL_ALT  = 8'h08;

    // lamp values
    localparam logic [7:0] VAL_CUE     = 8'h00;
    localparam logic [7:0] VAL_LOOP    = 8'h70;
    localparam logic [7:0] VAL_ROLL    = 8'h40;
    localparam logic [7:0] VAL_LIT     = 8'h0a;
    localparam logic [7:0] VAL_PRESSED = 8'h05;

    // pad flag bits
    localparam logic [2:0] F_LIT     = 3'b001;
    localparam logic [2:0] F_PRESSED = 3'b010;
    localparam logic [2:0] F_SYNCED  = 3'b100;

    // command budget of one item
    localparam int CNT_W = 6;
    localparam logic [CNT_W:0] MAX_CMDS     = 7'd60;
    localparam logic [CNT_W:0] CMDS_PER_PAD = 7'd6;

    typedef struct packed {
        logic load;
        logic event_step;
        logic clear_step;
        logic find_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic pad_end;
        logic more;
    } stat_t;

    // any real change of a pad's flags drops its synced mark
    function automatic logic [2:0] flag_change(logic [2:0] f, logic [2:0] set,
                                               logic [2:0] clr);
        logic [2:0] n;
        n = (f & ~clr) | set;
        return (n != f) ? (n & ~F_SYNCED) : f;
    endfunction

    function automatic logic [7:0] lamp_base(logic [1:0] mode);
        logic [7:0] v;
        case (mode)
            MODE_CUE:  v = VAL_CUE;
            MODE_LOOP: v = VAL_LOOP;
            MODE_ROLL: v = VAL_ROLL;
            default:   v = VAL_CUE;
        endcase
        return v;
    endfunction

endpackage

// ===== design/pcle_ctrl.sv =====
// sequencing state machine of the pad controller led event engine
module pcle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       func,
    input  pcle_pkg::stat_t  stat,
    output pcle_pkg::cmd_t   cmd,
    output logic             busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVENT = 5'b00010,
        S_CLEAR = 5'b00100,
        S_FIND  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (func)
                        pcle_pkg::FUNC_EVENT: state_next = S_EVENT;
                        pcle_pkg::FUNC_SYNC:  state_next = S_FIND;
                        pcle_pkg::FUNC_CLEAR: state_next = S_CLEAR;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_EVENT:
            begin
                cmd.event_step = 1'b1;
                state_next     = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                state_next     = S_FIND;
            end
            S_FIND:
            begin
                cmd.find_step = 1'b1;
                state_next    = stat.found ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (stat.pad_end && !stat.more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/pcle_datapath.sv =====
// pad flags, event decode, lamp command generation and result registers
module pcle_datapath #(
    parameter int PADS_PER_UNIT = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pcle_pkg::cmd_t   cmd,
    output pcle_pkg::stat_t  stat,
    input  logic [7:0]       status_byte,
    input  logic [7:0]       note_byte,
    input  logic [7:0]       velocity_byte,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic             cfg_wdata,
    output logic             result_valid,
    output logic [1:0]       kind,
    output logic             unit_right,
    output logic [1:0]       deck_action,
    output logic [2:0]       pad,
    output logic [7:0]       cmd_status,
    output logic [7:0]       cmd_note,
    output logic [7:0]       cmd_value,
    output logic             last
);

    localparam int PW = (PADS_PER_UNIT > 1) ? $clog2(PADS_PER_UNIT) : 1;
    localparam int CW = pcle_pkg::CNT_W;

    logic [2:0] flags_reg  [0:1][0:PADS_PER_UNIT-1];
    logic [2:0] flags_next [0:1][0:PADS_PER_UNIT-1];

    logic          left_present_reg;
    logic          right_present_reg;
    logic [7:0]    st_reg;
    logic [7:0]    nt_reg;
    logic [7:0]    vel_reg;

    logic          ptr_unit_reg;
    logic          ptr_unit_next;
    logic [PW-1:0] ptr_pad_reg;
    logic [PW-1:0] ptr_pad_next;
    logic [1:0]    mode_reg;
    logic [1:0]    mode_next;
    logic          shift_reg;
    logic          shift_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic          unit_reg;
    logic          unit_next;
    logic [1:0]    act_reg;
    logic [1:0]    act_next;
    logic [2:0]    pad_reg;
    logic [2:0]    pad_next;
    logic [7:0]    cst_reg;
    logic [7:0]    cst_next;
    logic [7:0]    cnt_note_reg;
    logic [7:0]    cnt_note_next;
    logic [7:0]    cval_reg;
    logic [7:0]    cval_next;
    logic          last_reg;
    logic          last_next;

    // event decode
    logic          is_plug;
    logic          is_left;
    logic          is_right;
    logic [7:0]    mode_full;
    logic [1:0]    ev_mode;
    logic          ev_present;
    logic [7:0]    plain_off;
    logic [7:0]    shift_off;
    logic          plain_ok;
    logic          shift_ok;
    logic          ev_shift;
    logic [PW-1:0] ev_pad;
    logic          vel_ok;
    logic          ev_on;
    logic [2:0]    ev_cur;
    logic [2:0]    ev_f1;
    logic [2:0]    ev_f2;
    logic          ev_result;
    logic          ev_reject;
    logic          ev_write;
    logic [1:0]    ev_act;

    // sync search and lamp values
    logic          srch_found;
    logic          srch_unit;
    logic [PW-1:0] srch_pad;
    logic [PW:0]   key_cur;
    logic          pad_end;
    logic          more;
    logic [2:0]    cur_flags;
    logic [7:0]    lamp_val;

    assign is_plug  = (st_reg == pcle_pkg::PLUG_STATUS)
                      && (nt_reg == pcle_pkg::PLUG_NOTE)
                      && ((vel_reg == pcle_pkg::VEL_RELEASE)
                          || (vel_reg == pcle_pkg::PLUG_VEL_ALT));

    assign is_left    = (st_reg >= pcle_pkg::ST_LEFT_BASE) && (st_reg <= pcle_pkg::ST_LEFT_TOP);
    assign is_right   = (st_reg >= pcle_pkg::ST_RIGHT_BASE)
                        && (st_reg <= pcle_pkg::ST_RIGHT_TOP);
    assign mode_full  = is_right ? (st_reg - pcle_pkg::ST_RIGHT_BASE)
                                 : (st_reg - pcle_pkg::ST_LEFT_BASE);
    assign ev_mode    = mode_full[1:0];
    assign ev_present = is_right ? right_present_reg : left_present_reg;
    assign plain_off  = nt_reg - pcle_pkg::NOTE_PLAIN;
    assign shift_off  = nt_reg - pcle_pkg::NOTE_SHIFT;
    assign plain_ok   = (nt_reg >= pcle_pkg::NOTE_PLAIN) && (plain_off < 8'(PADS_PER_UNIT));
    assign shift_ok   = (nt_reg >= pcle_pkg::NOTE_SHIFT) && (shift_off < 8'(PADS_PER_UNIT));
    // overlapping ranges: the unshifted reading wins
    assign ev_shift   = !plain_ok;
    assign ev_pad     = plain_ok ? plain_off[PW-1:0] : shift_off[PW-1:0];
    assign vel_ok     = (vel_reg == pcle_pkg::VEL_RELEASE) || (vel_reg == pcle_pkg::VEL_PRESS);
    assign ev_on      = (vel_reg == pcle_pkg::VEL_PRESS);
    assign ev_cur     = flags_reg[is_right][ev_pad];
    assign ev_f1      = ev_on ? pcle_pkg::flag_change(ev_cur, pcle_pkg::F_PRESSED, 3'b000)
                              : pcle_pkg::flag_change(ev_cur, 3'b000, pcle_pkg::F_PRESSED);

    always_comb
    begin
        ev_result = 1'b0;
        ev_reject = 1'b0;
        ev_write  = 1'b0;
        ev_act    = pcle_pkg::ACT_CUE;
        ev_f2     = ev_f1;
        if (is_plug)
        begin
            ev_result = 1'b0;
        end
        else if (!(is_left || is_right))
        begin
            ev_result = 1'b1;
            ev_reject = 1'b1;
        end
        else if (!ev_present)
        begin
            ev_result = 1'b0;
        end
        else if (!(plain_ok || shift_ok) || !vel_ok)
        begin
            ev_result = 1'b1;
            ev_reject = 1'b1;
        end
        else
        begin
            ev_write = 1'b1;
            if (ev_shift)
            begin
                if (ev_on)
                begin
                    ev_f2     = pcle_pkg::flag_change(ev_f1, 3'b000, pcle_pkg::F_LIT);
                    ev_result = 1'b1;
                    ev_act    = pcle_pkg::ACT_UNCUE;
                end
            end
            else if ((ev_mode == pcle_pkg::MODE_CUE) && ev_on)
            begin
                ev_f2     = pcle_pkg::flag_change(ev_f1, pcle_pkg::F_LIT, 3'b000);
                ev_result = 1'b1;
                ev_act    = pcle_pkg::ACT_CUE;
            end
            else if (ev_mode == pcle_pkg::MODE_LOOP)
            begin
                ev_result = 1'b1;
                if (ev_on)
                begin
                    ev_f2  = pcle_pkg::flag_change(ev_f1, pcle_pkg::F_LIT, 3'b000);
                    ev_act = pcle_pkg::ACT_PUNCH_IN;
                end
                else
                begin
                    ev_act = pcle_pkg::ACT_PUNCH_OUT;
                end
            end
        end
    end

    // lowest unsynced pad, after the current one while emitting
    assign key_cur = {ptr_unit_reg, ptr_pad_reg};

    always_comb
    begin
        srch_found = 1'b0;
        srch_unit  = 1'b0;
        srch_pad   = '0;
        for (int u = 1; u >= 0; u--)
        begin
            for (int p = PADS_PER_UNIT - 1; p >= 0; p--)
            begin
                if (!flags_reg[u][p][2]
                    && (cmd.find_step || ({1'(u), PW'(p)} > key_cur)))
                begin
                    srch_found = 1'b1;
                    srch_unit  = 1'(u);
                    srch_pad   = PW'(p);
                end
            end
        end
    end

    assign pad_end   = (mode_reg == pcle_pkg::MODE_ROLL) && shift_reg;
    // the next pad needs room for all six of its commands
    assign more      = srch_found
                       && ((7'(cnt_reg) + pcle_pkg::CMDS_PER_PAD + pcle_pkg::CMDS_PER_PAD)
                           <= pcle_pkg::MAX_CMDS);
    assign cur_flags = flags_reg[ptr_unit_reg][ptr_pad_reg];
    assign lamp_val  = pcle_pkg::lamp_base(mode_reg)
                       + (cur_flags[0] ? pcle_pkg::VAL_LIT : 8'h00)
                       + (cur_flags[1] ? pcle_pkg::VAL_PRESSED : 8'h00);

    assign stat.found   = srch_found;
    assign stat.pad_end = pad_end;
    assign stat.more    = more;

    always_comb
    begin
        flags_next     = flags_reg;
        ptr_unit_next  = ptr_unit_reg;
        ptr_pad_next   = ptr_pad_reg;
        mode_next      = mode_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        out_valid_next = 1'b0;
        kind_next      = kind_reg;
        unit_next      = unit_reg;
        act_next       = act_reg;
        pad_next       = pad_reg;
        cst_next       = cst_reg;
        cnt_note_next  = cnt_note_reg;
        cval_next      = cval_reg;
        last_next      = last_reg;

        if (cmd.event_step)
        begin
            if (ev_write)
            begin
                flags_next[is_right][ev_pad] = ev_f2;
            end
            if (ev_result)
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b1;
                cst_next       = 8'h00;
                cnt_note_next  = 8'h00;
                cval_next      = 8'h00;
                if (ev_reject)
                begin
                    kind_next = pcle_pkg::KIND_REJECT;
                    unit_next = 1'b0;
                    act_next  = pcle_pkg::ACT_CUE;
                    pad_next  = 3'd0;
                end
                else
                begin
                    kind_next = pcle_pkg::KIND_ACTION;
                    unit_next = is_right;
                    act_next  = ev_act;
                    pad_next  = 3'(ev_pad);
                end
            end
        end

        if (cmd.clear_step)
        begin
            for (int u = 0; u < 2; u++)
            begin
                for (int p = 0; p < PADS_PER_UNIT; p++)
                begin
                    flags_next[u][p] = pcle_pkg::flag_change(flags_reg[u][p], 3'b000,
                                                             pcle_pkg::F_LIT);
                end
            end
        end

        if (cmd.find_step)
        begin
            ptr_unit_next = srch_unit;
            ptr_pad_next  = srch_pad;
            mode_next     = pcle_pkg::MODE_CUE;
            shift_next    = 1'b0;
            cnt_next      = '0;
        end

        if (cmd.emit_step)
        begin
            out_valid_next = 1'b1;
            kind_next      = pcle_pkg::KIND_LAMP;
            unit_next      = ptr_unit_reg;
            act_next       = pcle_pkg::ACT_CUE;
            pad_next       = 3'(ptr_pad_reg);
            cst_next       = (ptr_unit_reg ? pcle_pkg::ST_RIGHT_BASE : pcle_pkg::ST_LEFT_BASE)
                             + 8'(mode_reg);
            cnt_note_next  = (shift_reg ? pcle_pkg::NOTE_SHIFT : pcle_pkg::NOTE_PLAIN)
                             + 8'(ptr_pad_reg);
            cval_next      = lamp_val;
            last_next      = pad_end && !more;
            shift_next     = !shift_reg;
            if (shift_reg)
            begin
                mode_next = mode_reg + 2'd1;
            end
            if (pad_end)
            begin
                flags_next[ptr_unit_reg][ptr_pad_reg] = cur_flags | pcle_pkg::F_SYNCED;
                cnt_next      = CW'(7'(cnt_reg) + pcle_pkg::CMDS_PER_PAD);
                ptr_unit_next = srch_unit;
                ptr_pad_next  = srch_pad;
                mode_next     = pcle_pkg::MODE_CUE;
                shift_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < 2; u++)
            begin
                for (int p = 0; p < PADS_PER_UNIT; p++)
                begin
                    flags_reg[u][p] <= 3'b000;
                end
            end
            left_present_reg  <= 1'b0;
            right_present_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    pcle_pkg::REG_LEFT_PRESENT:  left_present_reg  <= cfg_wdata;
                    pcle_pkg::REG_RIGHT_PRESENT: right_present_reg <= cfg_wdata;
                    default:                     left_present_reg  <= left_present_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg  <= status_byte;
            nt_reg  <= note_byte;
            vel_reg <= velocity_byte;
        end
        ptr_unit_reg <= ptr_unit_next;
        ptr_pad_reg  <= ptr_pad_next;
        mode_reg     <= mode_next;
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        kind_reg     <= kind_next;
        unit_reg     <= unit_next;
        act_reg      <= act_next;
        pad_reg      <= pad_next;
        cst_reg      <= cst_next;
        cnt_note_reg <= cnt_note_next;
        cval_reg     <= cval_next;
        last_reg     <= last_next;
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign unit_right   = unit_reg;
    assign deck_action  = act_reg;
    assign pad          = pad_reg;
    assign cmd_status   = cst_reg;
    assign cmd_note     = cnt_note_reg;
    assign cmd_value    = cval_reg;
    assign last         = last_reg;

endmodule

// ===== design/pad_controller_led_event_engine.sv =====
// note event: bytes registered on the transfer, decoded in the event state, result (if any) registered from it
// sync: a search state, then one lamp command per cycle, six per unsynced pad;
// clear first runs the unlight pass in its own state, then goes on like a sync
// up to 60 commands per item
// reset clears all pad flags and both deck-present registers at once; results cannot be stalled
module pad_controller_led_event_engine #(
    parameter int PADS_PER_UNIT = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] status_byte,
    input  logic [7:0] note_byte,
    input  logic [7:0] velocity_byte,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic       cfg_wdata,
    output logic       result_valid,
    output logic [1:0] kind,
    output logic       unit_right,
    output logic [1:0] deck_action,
    output logic [2:0] pad,
    output logic [7:0] cmd_status,
    output logic [7:0] cmd_note,
    output logic [7:0] cmd_value,
    output logic       last
);

    pcle_pkg::cmd_t  cmd;
    pcle_pkg::stat_t stat;

    pcle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pcle_datapath #(
        .PADS_PER_UNIT (PADS_PER_UNIT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .status_byte   (status_byte),
        .note_byte     (note_byte),
        .velocity_byte (velocity_byte),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .kind          (kind),
        .unit_right    (unit_right),
        .deck_action   (deck_action),
        .pad           (pad),
        .cmd_status    (cmd_status),
        .cmd_note      (cmd_note),
        .cmd_value     (cmd_value),
        .last          (last)
    );

    // a result that is not the final one only comes while a sync is still running
    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

    // nothing is emitted in the cycle right after an item is taken
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !result_valid)
        else $error("result right after item transfer");

    // a rejected event is always a single, final result
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == pcle_pkg::KIND_REJECT) |-> last)
        else $error("reject result not marked last");

    // a lamp command that is not final is followed by another result
    a_lamp_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == pcle_pkg::KIND_LAMP) && !last |=> result_valid)
        else $error("lamp command sequence broken");

endmodule
